FILE: src/ddo_pkg.sv
package ddo_pkg;

  localparam int FracBits = 16;

  localparam logic [1:0] KindLeft  = 2'd0;
  localparam logic [1:0] KindRight = 2'd1;
  localparam logic [1:0] KindTick  = 2'd2;

  localparam logic [1:0] CfgRadius = 2'd0;
  localparam logic [1:0] CfgTicks  = 2'd1;
  localparam logic [1:0] CfgSep    = 2'd2;

  localparam logic [15:0] RadiusReset = 16'd50000;
  localparam logic [15:0] TicksReset  = 16'd360;
  localparam logic [23:0] SepReset    = 24'd300000;

  localparam logic [63:0] TwoPiQ32  = 64'd26986075409;
  localparam logic [63:0] InvPiQ32  = 64'd1367130551;
  localparam logic [63:0] Micro     = 64'd1000000;
  localparam logic [63:0] MicroSq   = 64'd1000000000000;
  localparam logic [33:0] CordicX0  = 34'd652032874;

  typedef enum logic [3:0] {
    PhLMul  = 4'd0,
    PhLDiv  = 4'd1,
    PhRMul  = 4'd2,
    PhRDiv  = 4'd3,
    PhComb  = 4'd4,
    PhSMul  = 4'd5,
    PhSDiv  = 4'd6,
    PhCord1 = 4'd7,
    PhPosX  = 4'd8,
    PhPosY  = 4'd9,
    PhCord2 = 4'd10,
    PhVMul  = 4'd11,
    PhVDiv  = 4'd12,
    PhAMul  = 4'd13,
    PhADiv  = 4'd14,
    PhOut   = 4'd15
  } phase_e;

  typedef struct packed {
    phase_e phase;
    logic   accept;
    logic   go;
    logic   take;
  } cmd_t;

  typedef struct packed {
    logic tick;
    logic idle;
    logic out_free;
  } status_t;

  function automatic logic [31:0] atan_at(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933405;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335086;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41721;
      5'd15: v = 32'd20860;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2607;
      5'd19: v = 32'd1303;
      5'd20: v = 32'd651;
      5'd21: v = 32'd325;
      5'd22: v = 32'd162;
      5'd23: v = 32'd81;
      5'd24: v = 32'd40;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd2;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/ddo_engine.sv
module ddo_engine (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         mul_i,
  input  logic         div_i,
  input  logic [127:0] a_i,
  input  logic [63:0]  b_i,
  output logic [127:0] res_o,
  output logic         busy_o
);

  localparam logic [7:0] MulSteps = 8'd64;
  localparam logic [7:0] DivSteps = 8'd128;

  logic [127:0] x_q, x_d, acc_q, acc_d;
  logic [63:0]  y_q, y_d;
  logic [7:0]   cnt_q, cnt_d;
  logic         div_q, div_d;
  logic [64:0]  rem_sh, rem_nx;
  logic         fits;

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    div_d  = div_q;
    // restoring divide: remainder in the low bits of acc, quotient shifts into x
    rem_sh = {acc_q[63:0], x_q[127]};
    fits   = rem_sh >= {1'b0, y_q};
    rem_nx = fits ? rem_sh - {1'b0, y_q} : rem_sh;
    if (mul_i) begin
      x_d   = a_i;
      y_d   = b_i;
      acc_d = '0;
      cnt_d = MulSteps;
      div_d = 1'b0;
    end else if (div_i) begin
      x_d   = a_i;
      y_d   = b_i;
      acc_d = '0;
      cnt_d = DivSteps;
      div_d = 1'b1;
    end else if (cnt_q != 8'd0) begin
      cnt_d = cnt_q - 8'd1;
      if (div_q) begin
        acc_d = 128'(rem_nx);
        x_d   = {x_q[126:0], fits};
      end else begin
        if (y_q[0]) begin
          acc_d = acc_q + x_q;
        end
        x_d = {x_q[126:0], 1'b0};
        y_d = {1'b0, y_q[63:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      div_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      div_q <= div_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  assign res_o  = div_q ? x_q : acc_q;
  assign busy_o = cnt_q != 8'd0;

endmodule

FILE: src/ddo_cordic.sv
module ddo_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        ang_i,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o,
  output logic               busy_o
);

  localparam int IW = $clog2(CORDIC_STEPS);
  localparam logic [IW-1:0] LastStep = IW'(CORDIC_STEPS - 1);

  logic signed [33:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [33:0] xs, ys, at;
  logic [IW-1:0]      i_q, i_d;
  logic               busy_q, busy_d, flip_q, flip_d;
  logic               flip;
  logic [31:0]        ang_f;

  function automatic logic [31:0] atan_at_w(input logic [IW-1:0] idx);
    return ddo_pkg::atan_at(5'(idx));
  endfunction

  function automatic logic [33:0] CordicX0w();
    return ddo_pkg::CordicX0;
  endfunction

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    i_d    = i_q;
    busy_d = busy_q;
    flip_d = flip_q;
    // fold into [-pi/2, pi/2) by a half turn, undone by negating the results
    flip   = ang_i[31] ^ ang_i[30];
    ang_f  = {ang_i[31] ^ flip, ang_i[30:0]};
    xs     = x_q >>> i_q;
    ys     = y_q >>> i_q;
    at     = $signed(34'(atan_at_w(i_q)));
    if (start_i) begin
      x_d    = $signed(CordicX0w());
      y_d    = '0;
      z_d    = 34'($signed(ang_f));
      i_d    = '0;
      busy_d = 1'b1;
      flip_d = flip;
    end else if (busy_q) begin
      if (!z_q[33]) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end
      i_d = i_q + IW'(1);
      if (i_q == LastStep) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    i_q    <= i_d;
    flip_q <= flip_d;
  end

  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;
  assign busy_o = busy_q;

endmodule

FILE: src/ddo_datapath.sv
module ddo_datapath #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic [1:0]         kind_i,
  input  logic signed [31:0] count_i,
  input  logic [19:0]        elapsed_us_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [15:0] heading_o,
  output logic signed [15:0] quat_w_o,
  output logic signed [15:0] quat_z_o,
  output logic signed [31:0] lin_vel_o,
  output logic signed [31:0] ang_vel_o,
  input  ddo_pkg::cmd_t      cmd_i,
  output ddo_pkg::status_t   status_o
);

  localparam logic [63:0] DistLim = 64'h4000_0000_0000_0000;
  localparam logic [63:0] RateLim = 64'h0000_0000_7fff_ffff;

  logic [19:0] radius_q;
  logic [15:0] tpr_q;
  logic [23:0] sep_q;
  logic [31:0] xacc_q, yacc_q;
  logic [15:0] yaw_q;
  logic [31:0] ll_q, rl_q, lp_q, rp_q;
  logic        ls_q, rs_q;
  logic        out_valid_q;

  logic [19:0] el_q;
  logic [35:0] dv_q;
  logic        negl_q, negr_q;
  logic [63:0] dl_q, dr_q;
  logic        dneg_q, ddneg_q;
  logic [63:0] dmag_q, ddmag_q;
  logic [31:0] ddsat_q;
  logic [43:0] sepel_q;
  logic [31:0] step_q, mid_q;
  logic signed [65:0] prod_q;
  logic [15:0] qw_q, qz_q;
  logic [31:0] lin_q, ang_q;

  logic [15:0]  tpr_eff;
  logic [23:0]  sep_eff;
  logic [31:0]  side_u, side_mag;
  logic         side_neg;
  logic [51:0]  side_prod;
  logic [63:0]  sum, dd_sum, dd, diff, dmag_d, ddmag_d;
  logic [31:0]  ddsat_d;
  logic [31:0]  q32, stp, hs, half, mid_d;
  logic signed [33:0] cor_c, cor_s, csel;
  logic signed [65:0] prod_d;
  logic [65:0]  rnd;
  logic [31:0]  yaw32_new;
  logic [31:0]  half_ang;

  logic         eng_mul, eng_div, eng_busy;
  logic [127:0] eng_a, eng_res;
  logic [63:0]  eng_b;
  logic         cor_start, cor_busy;
  logic [31:0]  cor_ang;

  function automatic logic [63:0] sat_mag(input logic [127:0] q, input logic neg,
                                          input logic [63:0] maxpos);
    logic [63:0] lim, m;
    lim = neg ? maxpos + 64'd1 : maxpos;
    m   = (q > {64'd0, lim}) ? lim : q[63:0];
    return neg ? -m : m;
  endfunction

  function automatic logic [15:0] to_q15(input logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [19:0] r;
    logic [15:0]        res;
    t = 35'(v) + 35'sd16384;
    r = t[34:15];
    if (r > 20'sd32767) begin
      res = 16'h7fff;
    end else if (r < -20'sd32768) begin
      res = 16'h8000;
    end else begin
      res = r[15:0];
    end
    return res;
  endfunction

  assign cfg_ready_o = 1'b1;

  always_comb begin
    tpr_eff  = (tpr_q == 16'd0) ? 16'd1 : tpr_q;
    sep_eff  = (sep_q == 24'd0) ? 24'd1 : sep_q;

    side_u    = (cmd_i.phase == ddo_pkg::PhRMul) ? rl_q - rp_q : ll_q - lp_q;
    side_neg  = side_u[31];
    side_mag  = side_neg ? -side_u : side_u;
    side_prod = 52'(side_mag) * 52'(radius_q);

    // 64-bit wrapping sum and difference, halving truncates toward zero
    sum     = dl_q + dr_q;
    dd_sum  = sum + {63'd0, sum[63]};
    dd      = {dd_sum[63], dd_sum[63:1]};
    diff    = dr_q - dl_q;
    dmag_d  = diff[63] ? -diff : diff;
    ddmag_d = dd[63] ? -dd : dd;
    if (!dd[63] && dd[62:31] != 32'd0) begin
      ddsat_d = 32'h7fff_ffff;
    end else if (dd[63] && dd[62:31] != 32'hffff_ffff) begin
      ddsat_d = 32'h8000_0000;
    end else begin
      ddsat_d = dd[31:0];
    end

    q32   = eng_res[31:0];
    stp   = dneg_q ? -q32 : q32;
    hs    = stp + {31'd0, stp[31]};
    half  = {hs[31], hs[31:1]};
    mid_d = {yaw_q, 16'd0} + half;

    csel   = (cmd_i.phase == ddo_pkg::PhCord1) ? cor_c : cor_s;
    prod_d = $signed(ddsat_q) * csel;
    rnd    = prod_q + 66'd536870912;

    yaw32_new = {yaw_q, 16'd0} + step_q + 32'h0000_8000;
    half_ang  = {yaw_q[15], yaw_q, 15'd0};
  end

  always_comb begin
    eng_mul = 1'b0;
    eng_div = 1'b0;
    eng_a   = eng_res;
    eng_b   = ddo_pkg::Micro;
    case (cmd_i.phase) inside
      ddo_pkg::PhLMul, ddo_pkg::PhRMul: begin
        eng_mul = cmd_i.go;
        eng_a   = 128'(side_prod);
        eng_b   = ddo_pkg::TwoPiQ32;
      end
      ddo_pkg::PhLDiv, ddo_pkg::PhRDiv: begin
        eng_div = cmd_i.go;
        eng_a   = eng_res >> (32 - ddo_pkg::FracBits);
        eng_b   = 64'(dv_q);
      end
      ddo_pkg::PhComb: begin
        eng_mul = cmd_i.go;
        eng_a   = 128'(dmag_d);
        eng_b   = ddo_pkg::InvPiQ32;
      end
      ddo_pkg::PhSMul, ddo_pkg::PhVMul: begin
        eng_mul = cmd_i.go;
        eng_a   = (cmd_i.phase == ddo_pkg::PhVMul) ? 128'(ddmag_q) : eng_res;
        eng_b   = ddo_pkg::Micro;
      end
      ddo_pkg::PhSDiv: begin
        eng_div = cmd_i.go;
        eng_b   = 64'(sep_eff) << (ddo_pkg::FracBits + 1);
      end
      ddo_pkg::PhVDiv: begin
        eng_div = cmd_i.go;
        eng_b   = 64'(el_q);
      end
      ddo_pkg::PhAMul: begin
        eng_mul = cmd_i.go;
        eng_a   = 128'(dmag_q);
        eng_b   = ddo_pkg::MicroSq;
      end
      ddo_pkg::PhADiv: begin
        eng_div = cmd_i.go;
        eng_b   = 64'(sepel_q);
      end
      default: begin
      end
    endcase
  end

  assign cor_start = cmd_i.go &&
                     (cmd_i.phase == ddo_pkg::PhCord1 || cmd_i.phase == ddo_pkg::PhCord2);
  assign cor_ang   = (cmd_i.phase == ddo_pkg::PhCord1) ? mid_q : half_ang;

  ddo_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mul_i  (eng_mul),
    .div_i  (eng_div),
    .a_i    (eng_a),
    .b_i    (eng_b),
    .res_o  (eng_res),
    .busy_o (eng_busy)
  );

  ddo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .ang_i   (cor_ang),
    .cos_o   (cor_c),
    .sin_o   (cor_s),
    .busy_o  (cor_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= 20'(ddo_pkg::RadiusReset);
      tpr_q       <= ddo_pkg::TicksReset;
      sep_q       <= ddo_pkg::SepReset;
      xacc_q      <= '0;
      yacc_q      <= '0;
      yaw_q       <= '0;
      ll_q        <= '0;
      rl_q        <= '0;
      lp_q        <= '0;
      rp_q        <= '0;
      ls_q        <= 1'b0;
      rs_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          ddo_pkg::CfgRadius: radius_q <= cfg_data_i[19:0];
          ddo_pkg::CfgTicks:  tpr_q    <= cfg_data_i[15:0];
          ddo_pkg::CfgSep:    sep_q    <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.accept) begin
        case (kind_i)
          ddo_pkg::KindLeft: begin
            if (!ls_q) begin
              lp_q <= count_i;
            end
            ls_q <= 1'b1;
            ll_q <= count_i;
          end
          ddo_pkg::KindRight: begin
            if (!rs_q) begin
              rp_q <= count_i;
            end
            rs_q <= 1'b1;
            rl_q <= count_i;
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.go) begin
        case (cmd_i.phase)
          ddo_pkg::PhComb: begin
            lp_q <= ll_q;
            rp_q <= rl_q;
          end
          ddo_pkg::PhPosX: xacc_q <= xacc_q + rnd[61:30];
          ddo_pkg::PhPosY: begin
            yacc_q <= yacc_q + rnd[61:30];
            yaw_q  <= yaw32_new[31:16];
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.go && cmd_i.phase == ddo_pkg::PhOut) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      el_q <= elapsed_us_i;
    end
    if (cmd_i.go) begin
      case (cmd_i.phase)
        ddo_pkg::PhLMul: begin
          negl_q <= side_neg;
          dv_q   <= 36'(ddo_pkg::Micro) * 36'(tpr_eff);
        end
        ddo_pkg::PhRMul: negr_q <= side_neg;
        ddo_pkg::PhComb: begin
          dneg_q  <= diff[63];
          dmag_q  <= dmag_d;
          ddneg_q <= dd[63];
          ddmag_q <= ddmag_d;
          ddsat_q <= ddsat_d;
          sepel_q <= 44'(sep_eff) * 44'(el_q);
        end
        ddo_pkg::PhPosX: prod_q <= prod_d;
        ddo_pkg::PhOut: begin
          pos_x_o   <= xacc_q;
          pos_y_o   <= yacc_q;
          heading_o <= yaw_q;
          quat_w_o  <= qw_q;
          quat_z_o  <= qz_q;
          lin_vel_o <= lin_q;
          ang_vel_o <= ang_q;
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.take) begin
      case (cmd_i.phase)
        ddo_pkg::PhLDiv:  dl_q <= sat_mag(eng_res, negl_q, DistLim);
        ddo_pkg::PhRDiv:  dr_q <= sat_mag(eng_res, negr_q, DistLim);
        ddo_pkg::PhSDiv: begin
          step_q <= stp;
          mid_q  <= mid_d;
        end
        ddo_pkg::PhCord1: prod_q <= prod_d;
        ddo_pkg::PhCord2: begin
          qw_q <= to_q15(cor_c);
          qz_q <= to_q15(cor_s);
        end
        ddo_pkg::PhVDiv:  lin_q <= 32'(sat_mag(eng_res, ddneg_q, RateLim));
        ddo_pkg::PhADiv:  ang_q <= 32'(sat_mag(eng_res, dneg_q, RateLim));
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.tick     = (kind_i == ddo_pkg::KindTick) && (elapsed_us_i != 20'd0);
  assign status_o.idle     = !eng_busy && !cor_busy;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

FILE: src/ddo_ctrl.sv
module ddo_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ddo_pkg::status_t status_i,
  output ddo_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StGo   = 3'b010,
    StWait = 3'b100
  } state_e;

  state_e          state_q, state_d;
  ddo_pkg::phase_e phase_q, phase_d;

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    cmd_o.phase  = phase_q;
    cmd_o.accept = 1'b0;
    cmd_o.go     = 1'b0;
    cmd_o.take   = 1'b0;
    in_ready_o   = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.tick) begin
          phase_d = ddo_pkg::PhLMul;
          state_d = StGo;
        end
      end
      StGo: begin
        // the last phase waits for the output word to be free
        if (phase_q != ddo_pkg::PhOut || status_i.out_free) begin
          cmd_o.go = 1'b1;
          state_d  = StWait;
        end
      end
      StWait: begin
        if (status_i.idle) begin
          cmd_o.take = 1'b1;
          if (phase_q == ddo_pkg::PhOut) begin
            state_d = StIdle;
          end else begin
            phase_d = ddo_pkg::phase_e'(phase_q + 4'd1);
            state_d = StGo;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      phase_q <= ddo_pkg::PhLMul;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule

FILE: src/differential_drive_odometry.sv
// encoder words are accepted and the input is ready again right away
// a publish tick with nonzero elapsed time is worked through in phases on the serial
// multiply and divide unit, used six and five times, and then loads its result word;
// the input is ready again after that, one tick at a time, and a result word not yet
// taken holds the load
// reset (async, active low) clears pose, counts and latch flags, loads default config
module differential_drive_odometry #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic signed [31:0] count_i,
  input  logic [19:0]        elapsed_us_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [15:0] heading_o,
  output logic signed [15:0] quat_w_o,
  output logic signed [15:0] quat_z_o,
  output logic signed [31:0] lin_vel_o,
  output logic signed [31:0] ang_vel_o
);

  ddo_pkg::cmd_t    cmd;
  ddo_pkg::status_t status;

  ddo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ddo_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .kind_i       (kind_i),
    .count_i      (count_i),
    .elapsed_us_i (elapsed_us_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .heading_o    (heading_o),
    .quat_w_o     (quat_w_o),
    .quat_z_o     (quat_z_o),
    .lin_vel_o    (lin_vel_o),
    .ang_vel_o    (ang_vel_o),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule

FILE: src/ddo_checker.sv
module ddo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  kind_i,
  input logic [19:0] elapsed_us_i,
  input logic        out_valid_o,
  input logic        out_ready_i
);

  // result word holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped before taken");

  // a tick with time elapsed occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i == ddo_pkg::KindTick && elapsed_us_i != 20'd0
    |=> !in_ready_o)
    else $error("tick accepted without starting work");

  // encoder words never stall the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == ddo_pkg::KindLeft || kind_i == ddo_pkg::KindRight)
    |=> in_ready_o)
    else $error("encoder word stalled input");

  // a result appears only at the end of tick work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_ready_o)
    else $error("result without tick work");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (.*);

FILE: tb/differential_drive_odometry_checker.sv
`timescale 1ns / 100ps

module differential_drive_odometry_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         kind_i,
  input  logic signed [31:0] count_i,
  input  logic [19:0]        elapsed_us_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [15:0] heading_i,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [31:0] lin_vel_i,
  input  logic signed [31:0] ang_vel_i,
  output int                 pending_o,
  output int                 errors_o
);

  localparam logic [63:0] TwoPiFix = 64'd26986075409;
  localparam logic [63:0] InvPiFix = 64'd1367130551;
  localparam logic [63:0] Mega     = 64'd1000000;
  localparam longint      GainX0   = 64'sd652032874;
  localparam logic [31:0] Arctan [16] = '{
    32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335086,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860
  };

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] hd;
    logic [15:0] qw;
    logic [15:0] qz;
    logic [31:0] lv;
    logic [31:0] av;
  } pose_t;

  logic [19:0] radius;
  logic [15:0] tpr;
  logic [23:0] sep_um;
  logic [31:0] x_acc, y_acc, l_new, r_new, l_old, r_old;
  logic [15:0] yaw;
  logic        l_seen, r_seen;
  pose_t       pose_q[$];
  int          errors;

  assign pending_o = pose_q.size();
  assign errors_o  = errors;

  function automatic longint clamp_mag(logic [127:0] q, logic neg, logic [63:0] maxpos);
    logic [63:0] lim;
    logic [63:0] m;
    lim = neg ? maxpos + 64'd1 : maxpos;
    m = (q > 128'(lim)) ? lim : q[63:0];
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic longint track_dist(logic [31:0] latest, logic [31:0] prev);
    logic [31:0]  u;
    logic         neg;
    logic [63:0]  mag, t;
    logic [127:0] n;
    u = latest - prev;
    neg = u[31];
    mag = {32'd0, neg ? (32'd0 - u) : u};
    t = (tpr == 16'd0) ? 64'd1 : 64'(tpr);
    n = (128'(mag) * 128'(radius) * 128'(TwoPiFix)) >> 16;
    return clamp_mag(n / (128'(Mega) * 128'(t)), neg, 64'h4000000000000000);
  endfunction

  function automatic void rotate(input logic [31:0] ang, output longint c, output longint s);
    logic   flip;
    longint x, y, z, nx;
    flip = 1'b0;
    if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) begin
      ang = ang + 32'h80000000;
      flip = 1'b1;
    end
    x = GainX0;
    y = 0;
    z = longint'($signed(ang));
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(Arctan[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(Arctan[i]);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [15:0] to_q15(longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic void publish(input logic [19:0] el);
    longint       dl, dr, dd, diff, ddsat, c, s;
    logic         dneg, ddneg;
    logic [63:0]  dmag, ddmag, sep;
    logic [127:0] q;
    logic [31:0]  step, yaw32, mid, rounded, half_ang;
    int           half;
    pose_t        p;
    dl = track_dist(l_new, l_old);
    dr = track_dist(r_new, r_old);
    l_old = l_new;
    r_old = r_new;
    dd = (dl + dr) / 2;
    diff = dr - dl;
    dneg = diff < 0;
    dmag = dneg ? -diff : diff;
    ddneg = dd < 0;
    ddmag = ddneg ? -dd : dd;
    sep = (sep_um == 24'd0) ? 64'd1 : 64'(sep_um);
    q = 128'(dmag) * 128'(InvPiFix) * 128'(Mega) / 128'(sep << 17);
    step = q[31:0];
    if (dneg) step = 32'd0 - step;
    half = $signed(step) / 2;
    yaw32 = {yaw, 16'd0};
    mid = yaw32 + 32'(half);
    ddsat = (dd > 64'sd2147483647) ? 64'sd2147483647 :
            ((dd < -64'sd2147483648) ? -64'sd2147483648 : dd);
    rotate(mid, c, s);
    x_acc = x_acc + 32'((ddsat * c + (64'sd1 <<< 29)) >>> 30);
    y_acc = y_acc + 32'((ddsat * s + (64'sd1 <<< 29)) >>> 30);
    rounded = yaw32 + step + 32'h8000;
    yaw = rounded[31:16];
    half_ang = 32'(yaw) << 15;
    if (yaw[15]) half_ang = half_ang + 32'h80000000;
    rotate(half_ang, c, s);
    p.x = x_acc;
    p.y = y_acc;
    p.hd = yaw;
    p.qw = to_q15(c);
    p.qz = to_q15(s);
    p.lv = 32'(clamp_mag(128'(ddmag) * 128'(Mega) / 128'(el), ddneg, 64'h7fffffff));
    p.av = 32'(clamp_mag(128'(dmag) * 128'(Mega * Mega) / (128'(sep) * 128'(el)),
                         dneg, 64'h7fffffff));
    pose_q.push_back(p);
  endfunction

  task automatic report(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pose_t p;
    if (!rst_ni) begin
      radius = 20'd50000;
      tpr = 16'd360;
      sep_um = 24'd300000;
      x_acc = '0; y_acc = '0; yaw = '0;
      l_new = '0; r_new = '0; l_old = '0; r_old = '0;
      l_seen = 1'b0; r_seen = 1'b0;
      pose_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          ddo_pkg::CfgRadius: radius = cfg_data_i[19:0];
          ddo_pkg::CfgTicks:  tpr = cfg_data_i[15:0];
          ddo_pkg::CfgSep:    sep_um = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (pose_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word at %0t", $realtime);
        end else begin
          p = pose_q.pop_front();
          if (pos_x_i !== p.x) report("pos_x", p.x, pos_x_i);
          if (pos_y_i !== p.y) report("pos_y", p.y, pos_y_i);
          if (heading_i !== p.hd) report("heading", 32'(p.hd), 32'(heading_i));
          if (quat_w_i !== p.qw) report("quat_w", 32'(p.qw), 32'(quat_w_i));
          if (quat_z_i !== p.qz) report("quat_z", 32'(p.qz), 32'(quat_z_i));
          if (lin_vel_i !== p.lv) report("lin_vel", p.lv, lin_vel_i);
          if (ang_vel_i !== p.av) report("ang_vel", p.av, ang_vel_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (kind_i)
          ddo_pkg::KindLeft: begin
            if (!l_seen) begin
              l_old = count_i;
              l_seen = 1'b1;
            end
            l_new = count_i;
          end
          ddo_pkg::KindRight: begin
            if (!r_seen) begin
              r_old = count_i;
              r_seen = 1'b1;
            end
            r_new = count_i;
          end
          ddo_pkg::KindTick: if (elapsed_us_i != 20'd0) publish(elapsed_us_i);
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: tb/differential_drive_odometry_tb.sv
`timescale 1ns / 100ps

module differential_drive_odometry_tb;

  localparam int CycleLimit = 3000000;
  localparam int Drain      = 1200;
  localparam logic [1:0] KindIgnored = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [23:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         kind = '0;
  logic signed [31:0] count = '0;
  logic [19:0]        elapsed = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] pos_x, pos_y, lin_vel, ang_vel;
  logic signed [15:0] heading, quat_w, quat_z;
  int                 pending, errors;
  int                 cycles = 0;
  bit                 quiet = 0;
  bit                 stall_req = 0;
  bit                 stall_done = 0;
  int                 stall_left = 0;
  logic [31:0]        left_cnt = '0, right_cnt = '0;

  always #6 clk = ~clk;

  differential_drive_odometry uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .kind_i(kind), .count_i(count), .elapsed_us_i(elapsed),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .pos_x_o(pos_x), .pos_y_o(pos_y), .heading_o(heading),
    .quat_w_o(quat_w), .quat_z_o(quat_z), .lin_vel_o(lin_vel), .ang_vel_o(ang_vel)
  );

  differential_drive_odometry_checker pose_check (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .kind_i(kind), .count_i(count), .elapsed_us_i(elapsed),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .heading_i(heading),
    .quat_w_i(quat_w), .quat_z_i(quat_z), .lin_vel_i(lin_vel), .ang_vel_i(ang_vel),
    .pending_o(pending), .errors_o(errors)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random back-pressure plus one long hold-off
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (stall_req && !stall_done) begin
      stall_done = 1;
      stall_left = 20000;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= 7);
    end
  end

  task automatic send_word(logic [1:0] k, logic [31:0] c, logic [19:0] e);
    if (!quiet)
      while ($urandom_range(0, 99) < 7) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    in_valid <= 1'b1;
    kind <= k;
    count <= c;
    elapsed <= e;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (Drain) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(logic [23:0] r, logic [23:0] t, logic [23:0] s);
    wait_drained();
    write_reg(ddo_pkg::CfgRadius, r);
    write_reg(ddo_pkg::CfgTicks, t);
    write_reg(ddo_pkg::CfgSep, s);
  endtask

  function automatic logic [31:0] next_count(logic [31:0] last);
    if ($urandom_range(0, 99) < 5) return $urandom;
    return last + $urandom_range(0, 4000) - 32'd2000;
  endfunction

  function automatic logic [19:0] pick_elapsed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 20'd0;
    if (r < 10) return 20'($urandom_range(1, 10));
    if (r < 15) return 20'hFFFFF;
    if (r < 20) return 20'($urandom);
    return 20'($urandom_range(1000, 50000));
  endfunction

  task automatic run_random(int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        left_cnt = next_count(left_cnt);
        right_cnt = next_count(right_cnt);
        if ($urandom_range(0, 1)) begin
          send_word(ddo_pkg::KindLeft, left_cnt, 20'($urandom));
          send_word(ddo_pkg::KindRight, right_cnt, 20'($urandom));
        end else begin
          send_word(ddo_pkg::KindRight, right_cnt, 20'($urandom));
          send_word(ddo_pkg::KindLeft, left_cnt, 20'($urandom));
        end
        send_word(ddo_pkg::KindTick, $urandom, pick_elapsed());
        sent += 3;
      end else begin
        logic [1:0] k;
        k = 2'($urandom_range(0, 3));
        send_word(k, $urandom, 20'($urandom));
        if (k != KindIgnored) sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: tick before any reading, independent first latches, wrap, zero time
    send_word(ddo_pkg::KindTick, 32'd0, 20'd20000);
    send_word(ddo_pkg::KindLeft, 32'h7FFFFF00, 20'd0);
    send_word(ddo_pkg::KindTick, 32'd0, 20'd20000);
    send_word(ddo_pkg::KindLeft, 32'h800000FF, 20'd0);
    send_word(ddo_pkg::KindTick, 32'd0, 20'd0);
    send_word(ddo_pkg::KindRight, 32'h80000000, 20'd0);
    send_word(ddo_pkg::KindTick, 32'd0, 20'hFFFFF);
    send_word(ddo_pkg::KindRight, 32'h7FFFFFFF, 20'd0);
    send_word(KindIgnored, 32'hFFFFFFFF, 20'hFFFFF);
    send_word(ddo_pkg::KindTick, 32'hFFFFFFFF, 20'd1);
    send_word(ddo_pkg::KindLeft, 32'h00000000, 20'd0);
    send_word(ddo_pkg::KindRight, 32'h00001000, 20'd0);
    send_word(ddo_pkg::KindTick, 32'd0, 20'd1);
    send_word(ddo_pkg::KindLeft, 32'hFFFFFFFF, 20'd0);
    send_word(ddo_pkg::KindRight, 32'h00000FFF, 20'd0);
    send_word(ddo_pkg::KindTick, 32'd0, 20'd20000);

    // extreme scale: huge turn aliasing and saturation
    set_config(24'd1000000, 24'd1, 24'd1);
    send_word(ddo_pkg::KindLeft, 32'h00000000, 20'd0);
    send_word(ddo_pkg::KindRight, 32'h40000000, 20'd0);
    send_word(ddo_pkg::KindTick, 32'd0, 20'd1);
    send_word(ddo_pkg::KindLeft, 32'h80000000, 20'd0);
    send_word(ddo_pkg::KindTick, 32'd0, 20'hFFFFF);
    run_random(200);

    // zero ticks and separation act as one, zero radius gives no motion
    set_config(24'd0, 24'd0, 24'd0);
    quiet = 1;
    run_random(300);
    quiet = 0;

    set_config(24'd1, 24'd65535, 24'd10000000);
    run_random(300);

    set_config(24'd50000, 24'd360, 24'd300000);
    stall_req = 1;
    run_random(400);
    // sender waits out every outstanding result once
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    run_random(200);

    for (int ph = 0; ph < 3; ph++) begin
      set_config(24'($urandom_range(1, 1000000)), 24'($urandom_range(1, 65535)),
                 24'($urandom_range(1, 10000000)));
      run_random(200);
    end

    wait_drained();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
